// ===== src/mhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    // heap geometry
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // child index needs room for 2*pos+2
    localparam int CH_W     = ADDR_W + 2;

    // fixed port widths
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 11;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // action codes
    typedef enum logic {
        ACT_INSERT  = 1'b0,
        ACT_EXTRACT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        status_t                 status;
        logic [COUNT_W-1:0]      count;
    } result_t;

endpackage

`default_nettype wire

// ===== src/mhpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/mhpq_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhpq_seq (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            in_action,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0] in_key,
    output logic                                 res_valid,
    input  wire logic                            res_free,
    output mhpq_pkg::result_t                    res
);

    mhpq_pkg::state_t state_reg, state_next;
    mhpq_pkg::addr_t  pos_reg, pos_next;
    mhpq_pkg::cnt_t   cnt_reg, cnt_next;
    logic signed [mhpq_pkg::KEY_W-1:0] cur_reg, cur_next;
    logic signed [mhpq_pkg::KEY_W-1:0] best_reg, best_next;
    logic                              best_left_reg, best_left_next;
    logic signed [mhpq_pkg::KEY_W-1:0] value_reg, value_next;
    mhpq_pkg::status_t status_reg, status_next;

    // store port
    logic                              wr_en;
    mhpq_pkg::addr_t                   wr_addr;
    logic signed [mhpq_pkg::KEY_W-1:0] wr_data;
    logic                              rd_en;
    mhpq_pkg::addr_t                   rd_addr;
    logic signed [mhpq_pkg::KEY_W-1:0] rd_data;

    // shared comparator
    logic signed [mhpq_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic                              cmp_gt;

    logic [mhpq_pkg::CH_W-1:0] left_w, right_w, cnt_w;
    mhpq_pkg::addr_t           parent;
    logic                      left_out, right_in, full, empty;

    mhpq_ram #(
        .DEPTH  (mhpq_pkg::CAPACITY),
        .ADDR_W (mhpq_pkg::ADDR_W),
        .DATA_W (mhpq_pkg::KEY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign left_w   = {1'b0, pos_reg, 1'b1};
    assign right_w  = left_w + mhpq_pkg::CH_W'(1);
    assign cnt_w    = mhpq_pkg::CH_W'(cnt_reg);
    assign left_out = (left_w >= cnt_w);
    assign right_in = (right_w < cnt_w);
    assign parent   = (pos_reg - mhpq_pkg::ADDR_W'(1)) >> 1;
    assign full     = (cnt_reg == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY));
    assign empty    = (cnt_reg == '0);

    always_comb begin
        unique case (state_reg)
            mhpq_pkg::S_UP_CMP: begin
                cmp_a = cur_reg;
                cmp_b = rd_data;
            end
            mhpq_pkg::S_DN_R: begin
                cmp_a = rd_data;
                cmp_b = best_reg;
            end
            default: begin
                cmp_a = rd_data;
                cmp_b = cur_reg;
            end
        endcase
    end

    assign cmp_gt = (cmp_a > cmp_b);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mhpq_pkg::S_IDLE: begin
                if (in_valid) begin
                    if (in_action == mhpq_pkg::ACT_INSERT) begin
                        state_next = full ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP;
                    end else begin
                        state_next = empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_EX_ROOT;
                    end
                end
            end
            mhpq_pkg::S_UP: begin
                state_next = (pos_reg == '0) ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_CMP;
            end
            mhpq_pkg::S_UP_CMP: begin
                state_next = cmp_gt ? mhpq_pkg::S_UP : mhpq_pkg::S_DONE;
            end
            mhpq_pkg::S_EX_ROOT: begin
                state_next = empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_EX_LAST;
            end
            mhpq_pkg::S_EX_LAST: begin
                state_next = mhpq_pkg::S_DN;
            end
            mhpq_pkg::S_DN: begin
                state_next = left_out ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_L;
            end
            mhpq_pkg::S_DN_L: begin
                priority if (right_in) begin
                    state_next = mhpq_pkg::S_DN_R;
                end else if (cmp_gt) begin
                    state_next = mhpq_pkg::S_DN;
                end else begin
                    state_next = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DN_R: begin
                state_next = (cmp_gt || best_left_reg) ? mhpq_pkg::S_DN : mhpq_pkg::S_DONE;
            end
            mhpq_pkg::S_DONE: begin
                state_next = res_free ? mhpq_pkg::S_IDLE : mhpq_pkg::S_DONE;
            end
            default: begin
                state_next = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and store control; the moving key stays in cur_reg and is
    // written once when it settles
    always_comb begin
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = cur_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        unique case (state_reg)
            mhpq_pkg::S_IDLE: begin
                if (in_valid) begin
                    value_next  = '0;
                    status_next = mhpq_pkg::ST_OK;
                    if (in_action == mhpq_pkg::ACT_INSERT) begin
                        if (full) begin
                            status_next = mhpq_pkg::ST_FULL;
                        end else begin
                            cur_next = in_key;
                            pos_next = mhpq_pkg::ADDR_W'(cnt_reg);
                            cnt_next = cnt_reg + mhpq_pkg::CNT_W'(1);
                        end
                    end else begin
                        if (empty) begin
                            status_next = mhpq_pkg::ST_EMPTY;
                        end else begin
                            cnt_next = cnt_reg - mhpq_pkg::CNT_W'(1);
                            rd_en    = 1'b1;
                            rd_addr  = '0;
                        end
                    end
                end
            end
            mhpq_pkg::S_UP: begin
                if (pos_reg == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = parent;
                end
            end
            mhpq_pkg::S_UP_CMP: begin
                wr_en = 1'b1;
                if (cmp_gt) begin
                    wr_data  = rd_data;
                    pos_next = parent;
                end
            end
            mhpq_pkg::S_EX_ROOT: begin
                value_next = rd_data;
                if (!empty) begin
                    rd_en   = 1'b1;
                    rd_addr = mhpq_pkg::ADDR_W'(cnt_reg);
                end
            end
            mhpq_pkg::S_EX_LAST: begin
                cur_next = rd_data;
                pos_next = '0;
            end
            mhpq_pkg::S_DN: begin
                if (left_out) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = left_w[mhpq_pkg::ADDR_W-1:0];
                end
            end
            mhpq_pkg::S_DN_L: begin
                best_next      = cmp_gt ? rd_data : cur_reg;
                best_left_next = cmp_gt;
                priority if (right_in) begin
                    rd_en   = 1'b1;
                    rd_addr = right_w[mhpq_pkg::ADDR_W-1:0];
                end else if (cmp_gt) begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    pos_next = left_w[mhpq_pkg::ADDR_W-1:0];
                end else begin
                    wr_en = 1'b1;
                end
            end
            mhpq_pkg::S_DN_R: begin
                wr_en = 1'b1;
                priority if (cmp_gt) begin
                    wr_data  = rd_data;
                    pos_next = right_w[mhpq_pkg::ADDR_W-1:0];
                end else if (best_left_reg) begin
                    wr_data  = best_reg;
                    pos_next = left_w[mhpq_pkg::ADDR_W-1:0];
                end else begin
                    wr_data = cur_reg;
                end
            end
            mhpq_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mhpq_pkg::S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        cur_reg       <= cur_next;
        best_reg      <= best_next;
        best_left_reg <= best_left_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
    end

    assign in_ready     = (state_reg == mhpq_pkg::S_IDLE);
    assign res_valid    = (state_reg == mhpq_pkg::S_DONE);
    assign res.value    = value_reg;
    assign res.status   = status_reg;
    assign res.count    = mhpq_pkg::COUNT_W'(cnt_reg);

endmodule

`default_nettype wire

// ===== src/max_heap_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  beat fields              handshake
// s_        in         s_action, s_key          s_valid / s_ready
// m_        out        m_value, m_status, m_count  m_valid / m_ready
//
// one beat in, one beat out; one store read per cycle sets the pace. insert: the key
// climbs while it beats its parent; extract: the root and last key are read, then the
// last key sinks from the root while a child beats it; a refused beat, or an extract
// that empties the heap, skips the climb and sink. aresetn is synchronous, empties the
// heap, leaves the store. a finished result waits only while the output register is
// full and m_ready is low.

module max_heap_priority_queue_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_action,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0]   s_key,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [mhpq_pkg::KEY_W-1:0]        m_value,
    output logic [1:0]                               m_status,
    output logic [mhpq_pkg::COUNT_W-1:0]             m_count
);

    logic              res_valid;
    logic              res_free;
    mhpq_pkg::result_t res;

    logic              m_valid_reg, m_valid_next;
    mhpq_pkg::result_t m_res_reg, m_res_next;

    // heap sequencer with its store
    mhpq_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_action (s_action),
        .in_key    (s_key),
        .res_valid (res_valid),
        .res_free  (res_free),
        .res       (res)
    );

    // output register frees when empty or drained this cycle
    assign res_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_free) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_res_reg.value;
    assign m_status = m_res_reg.status;
    assign m_count  = m_res_reg.count;

endmodule

`default_nettype wire
